// ===== hw/rtl/utc_pkg.sv =====
// ----------------------------------------------------------------------------
// utc_pkg: shared definitions for the up-counting timer
// Command codes, register map, control bit positions and the item struct.
// ----------------------------------------------------------------------------
package utc_pkg;

	// counter width; the register bus stays 8 bits wide
	localparam int COUNT_WIDTH = 8;
	localparam int DATA_WIDTH  = 8;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// register byte addresses
	localparam logic [7:0] ADDR_CONTROL = 8'h00;
	localparam logic [7:0] ADDR_COUNT   = 8'h04;
	localparam logic [7:0] ADDR_COMPARE = 8'h08;
	localparam logic [7:0] ADDR_STATUS  = 8'h0C;

	// control register bits
	localparam int CTRL_ENABLE_BIT = 0;
	localparam int CTRL_CMP_EN_BIT = 1;
	localparam int CTRL_OVF_EN_BIT = 2;

	// status register bits (write one to clear)
	localparam int STAT_CMP_BIT = 0;
	localparam int STAT_OVF_BIT = 1;

	typedef struct packed {
		logic [1:0]            command;
		logic [7:0]            address;
		logic [DATA_WIDTH-1:0] write_data;
	} utc_item_t;

endpackage

// ===== hw/rtl/utc_in_reg.sv =====
// ----------------------------------------------------------------------------
// utc_in_reg: input register stage
// Holds one accepted transfer; refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module utc_in_reg
	import utc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  utc_item_t in_item,
	output logic      valid_s1,
	output utc_item_t item_s1,
	input  logic      take_s1
);

	assign in_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/utc_core.sv =====
// ----------------------------------------------------------------------------
// utc_core: timer registers and result register
// Decodes one item, updates count/flags/registers, registers the result.
// ----------------------------------------------------------------------------
module utc_core
	import utc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  utc_item_t             item_s1,
	output logic                  take_s1,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] read_data,
	output logic                  overflow_irq,
	output logic                  compare_irq
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	logic [DATA_WIDTH-1:0]  ctrl_q, ctrl_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic [DATA_WIDTH-1:0]  cmp_q, cmp_d;
	logic                   ovf_q, ovf_d;
	logic                   match_q, match_d;
	logic [DATA_WIDTH-1:0]  rd_d;
	logic [31:0]            cnt_wide;
	logic [31:0]            cmp_wide;
	logic [DATA_WIDTH-1:0]  cnt_byte;
	logic [COUNT_WIDTH-1:0] cmp_cnt;

	// result register drains or is empty
	assign take_s1 = valid_s1 && (!out_valid || out_ready);

	// width adapters between the 8-bit bus and the counter
	assign cnt_wide = 32'(cnt_q);
	assign cmp_wide = 32'(cmp_q);
	assign cnt_byte = cnt_wide[DATA_WIDTH-1:0];
	assign cmp_cnt  = cmp_wide[COUNT_WIDTH-1:0];

	always_comb begin
		ctrl_d  = ctrl_q;
		cnt_d   = cnt_q;
		cmp_d   = cmp_q;
		ovf_d   = ovf_q;
		match_d = match_q;
		rd_d    = '0;
		case (item_s1.command)
			CMD_TICK: begin
				if (ctrl_q[CTRL_ENABLE_BIT]) begin
					if (cnt_q == CNT_MAX) begin
						cnt_d = '0;
						if (ctrl_q[CTRL_OVF_EN_BIT]) begin
							ovf_d = 1'b1;
						end
					end else begin
						cnt_d = cnt_q + CNT_ONE;
						ovf_d = 1'b0;
					end
					match_d = ctrl_q[CTRL_CMP_EN_BIT] && (cnt_d == cmp_cnt);
				end
			end
			CMD_READ: begin
				case (item_s1.address)
					ADDR_CONTROL: rd_d = ctrl_q;
					ADDR_COUNT:   rd_d = cnt_byte;
					ADDR_COMPARE: rd_d = cmp_q;
					default:      rd_d = '0;
				endcase
			end
			CMD_WRITE: begin
				case (item_s1.address)
					ADDR_CONTROL: ctrl_d = item_s1.write_data;
					ADDR_COMPARE: cmp_d  = item_s1.write_data;
					ADDR_STATUS: begin
						if (item_s1.write_data[STAT_OVF_BIT]) begin
							ovf_d = 1'b0;
						end
						if (item_s1.write_data[STAT_CMP_BIT]) begin
							match_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= '0;
			cnt_q     <= '0;
			cmp_q     <= '0;
			ovf_q     <= 1'b0;
			match_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take_s1) begin
				ctrl_q  <= ctrl_d;
				cnt_q   <= cnt_d;
				cmp_q   <= cmp_d;
				ovf_q   <= ovf_d;
				match_q <= match_d;
			end
			if (take_s1) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result payload, loaded with the item that produced it
	always_ff @(posedge clk) begin
		if (take_s1) begin
			read_data    <= rd_d;
			overflow_irq <= ovf_d;
			compare_irq  <= match_d;
		end
	end

	// count moves only on a tick
	a_cnt_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && (item_s1.command != CMD_TICK) |=> $stable(cnt_q))
		else $error("count changed on a non-tick item");

	// only reads produce nonzero read data
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && (item_s1.command != CMD_READ) |=> (read_data == '0))
		else $error("read data nonzero for a non-read item");

	// overflow flag rises only on an enabled wrap
	a_ovf_rise: assert property (@(posedge clk) disable iff (!arst_n)
		!ovf_q && ovf_d && take_s1 |->
			(item_s1.command == CMD_TICK) && (cnt_q == CNT_MAX) &&
			ctrl_q[CTRL_OVF_EN_BIT])
		else $error("overflow flag set without a wrap");

	// after an enabled tick the compare flag tracks the match
	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && (item_s1.command == CMD_TICK) && ctrl_q[CTRL_ENABLE_BIT] |=>
			(match_q == (ctrl_q[CTRL_CMP_EN_BIT] && (cnt_q == cmp_cnt))))
		else $error("compare flag does not track count match");

	// result register agrees with live flags right after an update
	a_flag_out: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> (overflow_irq == ovf_q) && (compare_irq == match_q))
		else $error("result flags differ from status flags");

endmodule

// ===== hw/rtl/up_timer_compare_overflow.sv =====
// ----------------------------------------------------------------------------
// up_timer_compare_overflow: up-counting timer with compare/overflow flags
// Result path: input register, then result register (out_valid, read_data, irqs).
// Throughput: one item per cycle while out_ready keeps the result register draining.
// A result waiting on out_ready stalls the core; in_ready drops once the input
// register also holds an item.
// Reset (arst_n low, async): count, control, compare and flags cleared, both
// pipeline stages emptied.
// ----------------------------------------------------------------------------
module up_timer_compare_overflow
	import utc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel: tick, register read or register write
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            command,
	input  logic [7:0]            address,
	input  logic [DATA_WIDTH-1:0] write_data,
	// result channel: one result per input item
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] read_data,
	output logic                  overflow_irq,
	output logic                  compare_irq
);

	utc_item_t in_item;
	utc_item_t item_s1;
	logic      valid_s1;
	logic      take_s1;

	// pack the bus fields into one item
	assign in_item.command    = command;
	assign in_item.address    = address;
	assign in_item.write_data = write_data;

	// stage 1: input register; takes a new transfer whenever it empties
	utc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take_s1  (take_s1)
	);

	// stage 2: register file, counter update and result register.
	// State commits at the same edge the result is captured, so items
	// see each other's effects in strict arrival order.
	utc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.take_s1      (take_s1),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.overflow_irq (overflow_irq),
		.compare_irq  (compare_irq)
	);

endmodule
